[hw/rtl/gmmp_pkg.sv]
// gmmp_pkg: widths, limits and shared types of the gold mine max path core
// no dependencies
package gmmp_pkg;

   localparam int MAX_ROWS = 64;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int SIZE_W   = ROW_W + 1;
   localparam int GOLD_W   = 16;
   localparam int SUM_W    = 23;
   localparam int OUT_W    = 22;
   localparam int CFG_W    = 7;

   typedef logic [GOLD_W-1:0] gold_type;
   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [OUT_W-1:0]  best_type;
   typedef logic [CFG_W-1:0]  grid_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [SIZE_W-1:0] size_type;

   localparam sum_type  SUM_LIMIT  = '1;
   localparam best_type OUT_LIMIT  = '1;
   localparam grid_type GRID_RESET = CFG_W'(4);

   typedef struct packed {
      logic shift;
      logic insert;
   } cell_ctrl_type;

   typedef struct packed {
      logic    shift;
      row_type tail;
   } chain_ctrl_type;

endpackage

[hw/rtl/gmmp_channels.sv]
// gmmp channel interfaces: gold beats in, best total out, grid size writes
// depends on gmmp_pkg
interface gmmp_req_if;
   logic               valid;
   logic               ready;
   gmmp_pkg::gold_type gold;
   modport source(output valid, output gold, input ready);
   modport sink(input valid, input gold, output ready);
endinterface

interface gmmp_rsp_if;
   logic               valid;
   logic               ready;
   gmmp_pkg::best_type best_total;
   modport source(output valid, output best_total, input ready);
   modport sink(input valid, input best_total, output ready);
endinterface

interface gmmp_csr_if;
   logic               valid;
   logic               ready;
   gmmp_pkg::grid_type grid_size;
   modport source(output valid, output grid_size, input ready);
   modport sink(input valid, input grid_size, output ready);
endinterface

[hw/rtl/gmmp_cell.sv]
// gmmp_cell: one row's path sum, shifted toward the head of the chain
// depends on gmmp_pkg
module gmmp_cell (
   input  logic                    clock,
   input  gmmp_pkg::cell_ctrl_type ctrl,
   input  gmmp_pkg::sum_type       from_next,
   input  gmmp_pkg::sum_type       new_sum,
   output gmmp_pkg::sum_type       sum
);
   import gmmp_pkg::*;

   sum_type sum_ff;
   sum_type sum_in;

   always_comb begin
      sum_in = ctrl.insert ? new_sum : from_next;
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

[hw/rtl/gmmp_chain.sv]
// gmmp_chain: row of cells holding the previous column's sums in row order
// depends on gmmp_pkg and gmmp_cell
module gmmp_chain (
   input  logic                     clock,
   input  gmmp_pkg::chain_ctrl_type ctrl,
   input  gmmp_pkg::sum_type        new_sum,
   output gmmp_pkg::sum_type        head_sum,
   output gmmp_pkg::sum_type        next_sum
);
   import gmmp_pkg::*;

   sum_type sums [MAX_ROWS];

   for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
      cell_ctrl_type cell_ctrl;
      sum_type       from_next;

      assign cell_ctrl.shift  = ctrl.shift;
      assign cell_ctrl.insert = (ctrl.tail == ROW_W'(i));

      if (i == MAX_ROWS - 1) begin : g_tail
         assign from_next = new_sum;
      end else begin : g_body
         assign from_next = sums[i+1];
      end

      gmmp_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .from_next (from_next),
         .new_sum   (new_sum),
         .sum       (sums[i])
      );
   end

   assign head_sum = sums[0];
   assign next_sum = sums[1];

endmodule

[hw/rtl/gold_mine_max_path_core.sv]
// gold_mine_max_path_core: streamed gold mine max path over a square grid
// depends on gmmp_pkg, gmmp_channels and gmmp_chain
// best total is shown in the cycle after the grid's last gold beat is taken
// throughput: one gold beat per cycle while ready is high; a grid of n by n takes n*n beats
// the last beat of a grid waits only while the previous best total is still held
// reset: grid size 4, position and running best cleared, cell chain left as is
module gold_mine_max_path_core (
   input  logic       clock,
   input  logic       reset,
   gmmp_req_if.sink   req_bus,
   gmmp_rsp_if.source rsp_bus,
   gmmp_csr_if.sink   csr_bus
);
   import gmmp_pkg::*;

   grid_type grid_size_ff;
   row_type  row_ff, row_in;
   row_type  col_ff, col_in;
   sum_type  held_ff, held_in;
   sum_type  best_ff, best_in;
   logic     rsp_valid_ff, rsp_valid_in;
   best_type rsp_data_ff, rsp_data_in;

   size_type       size;
   size_type       size_m1;
   logic           last_row;
   logic           last_col;
   logic           first_col;
   logic           grid_last;
   logic           req_accept;
   logic           csr_accept;
   sum_type        head_sum;
   sum_type        next_sum;
   sum_type        up_sum;
   sum_type        down_sum;
   sum_type        max_a;
   sum_type        prior;
   logic [SUM_W:0] total_wide;
   sum_type        total;
   sum_type        best_next;
   best_type       best_out;
   chain_ctrl_type chain_ctrl;

   always_comb begin
      if (grid_size_ff == '0) begin
         size = SIZE_W'(1);
      end else if (32'(grid_size_ff) > MAX_ROWS) begin
         size = SIZE_W'(MAX_ROWS);
      end else begin
         size = SIZE_W'(grid_size_ff);
      end
   end

   assign size_m1   = size - SIZE_W'(1);
   assign last_row  = (row_ff == size_m1[ROW_W-1:0]);
   assign last_col  = (col_ff == size_m1[ROW_W-1:0]);
   assign first_col = (col_ff == '0);
   assign grid_last = last_row && last_col;

   assign req_bus.ready = !(rsp_valid_ff && !rsp_bus.ready && grid_last);
   assign csr_bus.ready = 1'b1;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign csr_accept    = csr_bus.valid && csr_bus.ready;

   assign chain_ctrl.shift = req_accept;
   assign chain_ctrl.tail  = size_m1[ROW_W-1:0];

   gmmp_chain u_chain (
      .clock    (clock),
      .ctrl     (chain_ctrl),
      .new_sum  (total),
      .head_sum (head_sum),
      .next_sum (next_sum)
   );

   always_comb begin
      up_sum   = (row_ff != '0) ? held_ff : '0;
      down_sum = last_row ? '0 : next_sum;
      max_a    = (up_sum >= head_sum) ? up_sum : head_sum;
      prior    = first_col ? '0 : ((max_a >= down_sum) ? max_a : down_sum);
      total_wide = {1'b0, prior} + (SUM_W+1)'(req_bus.gold);
      total    = total_wide[SUM_W] ? SUM_LIMIT : total_wide[SUM_W-1:0];
      best_next = (best_ff >= total) ? best_ff : total;
      best_out = (best_next > SUM_W'(OUT_LIMIT)) ? OUT_LIMIT : best_next[OUT_W-1:0];
   end

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      held_in      = held_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      if (csr_accept) begin
         row_in  = '0;
         col_in  = '0;
         held_in = '0;
         best_in = '0;
      end else if (req_accept) begin
         held_in = first_col ? '0 : head_sum;
         best_in = best_next;
         row_in  = last_row ? '0 : row_ff + ROW_W'(1);
         if (last_row) begin
            col_in = last_col ? '0 : col_ff + ROW_W'(1);
         end
         if (grid_last) begin
            held_in      = '0;
            best_in      = '0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = best_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= GRID_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         held_ff      <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_accept) begin
            grid_size_ff <= csr_bus.grid_size;
         end
         row_ff       <= row_in;
         col_ff       <= col_in;
         held_ff      <= held_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.best_total = rsp_data_ff;

   a_pos_in_grid: assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < 32'(size)) && (32'(col_ff) < 32'(size)))
      else $error("position outside grid");

   a_last_beat_shows: assert property (@(posedge clock) disable iff (reset)
      req_accept && grid_last && !csr_accept |=> rsp_valid_ff)
      else $error("last beat of grid gave no result");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(rsp_bus.ready))
      else $error("result dropped before taken");

   a_best_grows: assert property (@(posedge clock) disable iff (reset)
      req_accept && !grid_last && !csr_accept |=> best_ff >= $past(total))
      else $error("running best below a path sum");

endmodule
